// ===== hdl/rm2d_pkg.sv =====
// Package for the two-level rectangle minimum tree.
// Holds the shared codes, the controller/datapath command and status types and
// the signed minimum helper. Depends on nothing.
package rm2d_pkg;

    localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLR,
        DP_LOAD,
        DP_LEAF_WR,
        DP_QO_LEFT,
        DP_QO_RIGHT,
        DP_QO_SHIFT,
        DP_QI_LEFT,
        DP_QI_RIGHT,
        DP_QI_SHIFT,
        DP_PA_RD,
        DP_PB_RD,
        DP_P_WR,
        DP_OUT_UP,
        DP_EMIT
    } t_dp_cmd;

    typedef struct packed {
        logic wr_ok;
        logic q_nonempty;
        logic clr_last;
        logic l_lt_r;
        logic ol_odd;
        logic or_odd;
        logic il_lt_ir;
        logic il_odd;
        logic ir_odd;
        logic cj_gt1;
        logic oi_gt1;
    } t_dp_stat;

    function automatic logic signed [31:0] smin(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        smin = (a <= b) ? a : b;
    endfunction

endpackage

// ===== hdl/rm2d_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module rm2d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/rm2d_ctrl.sv =====
// Sequencer for the rectangle minimum tree: clearing pass, cell write with
// tree refresh, and rectangle query. Depends on rm2d_pkg.
module rm2d_ctrl import rm2d_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_opcode,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_W_LEAF, S_CLIMB, S_PA, S_PB, S_PW,
        S_Q_CHK, S_Q_OL, S_Q_OR, S_Q_SH,
        S_I_CHK, S_I_L, S_I_R, S_I_S, S_EMIT
    } t_state;

    t_state  r_state, n_state;
    logic    r_ret_sh, n_ret_sh;
    logic    r_busy;
    t_dp_cmd n_cmd;

    always_comb begin
        n_state  = r_state;
        n_ret_sh = r_ret_sh;
        n_cmd    = DP_NOP;
        case (r_state)
            S_CLEAR: begin
                n_cmd = DP_CLR;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    n_cmd = DP_LOAD;
                    if (i_opcode == OP_WRITE) begin
                        n_state = i_stat.wr_ok ? S_W_LEAF : S_IDLE;
                    end else begin
                        n_state = i_stat.q_nonempty ? S_Q_CHK : S_EMIT;
                    end
                end
            end
            S_W_LEAF: begin
                n_cmd   = DP_LEAF_WR;
                n_state = S_CLIMB;
            end
            S_CLIMB: begin
                if (i_stat.cj_gt1) begin
                    n_state = S_PA;
                end else if (i_stat.oi_gt1) begin
                    n_cmd   = DP_OUT_UP;
                    n_state = S_PA;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PA: begin
                n_cmd   = DP_PA_RD;
                n_state = S_PB;
            end
            S_PB: begin
                n_cmd   = DP_PB_RD;
                n_state = S_PW;
            end
            S_PW: begin
                n_cmd   = DP_P_WR;
                n_state = S_CLIMB;
            end
            S_Q_CHK: begin
                n_state = i_stat.l_lt_r ? S_Q_OL : S_EMIT;
            end
            S_Q_OL: begin
                if (i_stat.ol_odd) begin
                    n_cmd    = DP_QO_LEFT;
                    n_ret_sh = 1'b0;
                    n_state  = S_I_CHK;
                end else begin
                    n_state = S_Q_OR;
                end
            end
            S_Q_OR: begin
                if (i_stat.or_odd) begin
                    n_cmd    = DP_QO_RIGHT;
                    n_ret_sh = 1'b1;
                    n_state  = S_I_CHK;
                end else begin
                    n_state = S_Q_SH;
                end
            end
            S_Q_SH: begin
                n_cmd   = DP_QO_SHIFT;
                n_state = S_Q_CHK;
            end
            S_I_CHK: begin
                if (i_stat.il_lt_ir) n_state = S_I_L;
                else n_state = r_ret_sh ? S_Q_SH : S_Q_OR;
            end
            S_I_L: begin
                if (i_stat.il_odd) n_cmd = DP_QI_LEFT;
                n_state = S_I_R;
            end
            S_I_R: begin
                if (i_stat.ir_odd) n_cmd = DP_QI_RIGHT;
                n_state = S_I_S;
            end
            S_I_S: begin
                n_cmd   = DP_QI_SHIFT;
                n_state = S_I_CHK;
            end
            S_EMIT: begin
                n_cmd   = DP_EMIT;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_ret_sh <= 1'b0;
            r_busy   <= 1'b1;
        end else begin
            r_state  <= n_state;
            r_ret_sh <= n_ret_sh;
            r_busy   <= (n_state != S_IDLE);
        end
    end

    assign o_cmd  = n_cmd;
    assign o_busy = r_busy;
endmodule

// ===== hdl/rm2d_dp.sv =====
// Datapath of the rectangle minimum tree: node store, index registers,
// address generation and the running minimum. Depends on rm2d_pkg, rm2d_ram.
module rm2d_dp import rm2d_pkg::*; #(
    parameter int ROWS = 64,
    parameter int COLS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic [5:0]         i_row_lo,
    input  logic [5:0]         i_col_lo,
    input  logic [5:0]         i_row_hi,
    input  logic [5:0]         i_col_hi,
    input  logic signed [31:0] i_cell_value,
    output logic signed [31:0] o_range_min,
    output logic               o_done
);
    localparam int RW    = $clog2(ROWS);
    localparam int RP    = 1 << RW;
    localparam int CW    = $clog2(COLS);
    localparam int CP    = 1 << CW;
    localparam int OIW   = RW + 1;
    localparam int ORW   = RW + 2;
    localparam int CIW   = CW + 1;
    localparam int CRW   = CW + 2;
    localparam int AW    = OIW + CIW;
    localparam int DEPTH = 1 << AW;

    logic [ORW-1:0]     r_ol, r_or, w_orm1;
    logic [OIW-1:0]     r_oi;
    logic [CRW-1:0]     r_il, r_ir, w_irm1, w_il0, w_ir0;
    logic [CIW-1:0]     r_ij, r_cj;
    logic [CW-1:0]      r_c0, r_c1;
    logic signed [31:0] r_best, r_tmp, r_val, r_out;
    logic               r_pend, r_outer, r_done;
    logic [AW-1:0]      r_clr;

    logic [31:0]        w_rlo, w_clo, w_rhi, w_chi, w_r1, w_c1;
    logic [AW-1:0]      w_aa, w_ab, w_pa, w_waddr, w_raddr;
    logic               w_we;
    logic signed [31:0] w_wdata, w_rdata;

    // Input range checks and clipping of the query rectangle to the grid.
    assign w_rlo = 32'(i_row_lo);
    assign w_clo = 32'(i_col_lo);
    assign w_rhi = 32'(i_row_hi);
    assign w_chi = 32'(i_col_hi);
    assign w_r1  = (w_rhi >= 32'(ROWS)) ? 32'(ROWS - 1) : w_rhi;
    assign w_c1  = (w_chi >= 32'(COLS)) ? 32'(COLS - 1) : w_chi;

    assign w_orm1 = r_or - 1'b1;
    assign w_irm1 = r_ir - 1'b1;
    assign w_il0  = CRW'(32'(r_c0) + 32'(CP));
    assign w_ir0  = CRW'(32'(r_c1) + 32'(CP) + 32'd1);

    // Refresh pair: two children and the parent, inner or outer direction.
    assign w_aa = r_outer ? {r_oi[RW-1:0], 1'b0, r_ij} : {r_oi, r_cj[CW:1], 1'b0};
    assign w_ab = r_outer ? {r_oi[RW-1:0], 1'b1, r_ij} : {r_oi, r_cj[CW:1], 1'b1};
    assign w_pa = r_outer ? {r_oi, r_ij} : {r_oi, 1'b0, r_cj[CW:1]};

    always_comb begin
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = INT_MAX;
        w_raddr = '0;
        case (i_cmd)
            DP_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
            end
            DP_LEAF_WR: begin
                w_we    = 1'b1;
                w_waddr = {r_oi, r_ij};
                w_wdata = r_val;
            end
            DP_P_WR: begin
                w_we    = 1'b1;
                w_waddr = w_pa;
                w_wdata = smin(r_tmp, w_rdata);
            end
            DP_QI_LEFT:  w_raddr = {r_oi, r_il[CW:0]};
            DP_QI_RIGHT: w_raddr = {r_oi, w_irm1[CW:0]};
            DP_PA_RD:    w_raddr = w_aa;
            DP_PB_RD:    w_raddr = w_ab;
            default:     w_raddr = '0;
        endcase
    end

    rm2d_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_nodes (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
            r_outer <= 1'b0;
        end else begin
            r_pend <= (i_cmd == DP_QI_LEFT) || (i_cmd == DP_QI_RIGHT);
            r_done <= (i_cmd == DP_EMIT);
            // A node read issued last cycle folds into the running minimum.
            if (r_pend) r_best <= smin(r_best, w_rdata);
            case (i_cmd)
                DP_CLR: r_clr <= r_clr + 1'b1;
                DP_LOAD: begin
                    r_best  <= INT_MAX;
                    r_val   <= i_cell_value;
                    r_oi    <= OIW'(w_rlo + 32'(RP));
                    r_ij    <= CIW'(w_clo + 32'(CP));
                    r_cj    <= CIW'(w_clo + 32'(CP));
                    r_ol    <= ORW'(w_rlo + 32'(RP));
                    r_or    <= ORW'(w_r1 + 32'(RP) + 32'd1);
                    r_c0    <= CW'(w_clo);
                    r_c1    <= CW'(w_c1);
                    r_outer <= 1'b0;
                end
                DP_QO_LEFT: begin
                    r_oi <= r_ol[RW:0];
                    r_ol <= r_ol + 1'b1;
                    r_il <= w_il0;
                    r_ir <= w_ir0;
                end
                DP_QO_RIGHT: begin
                    r_or <= w_orm1;
                    r_oi <= w_orm1[RW:0];
                    r_il <= w_il0;
                    r_ir <= w_ir0;
                end
                DP_QO_SHIFT: begin
                    r_ol <= r_ol >> 1;
                    r_or <= r_or >> 1;
                end
                DP_QI_LEFT:  r_il <= r_il + 1'b1;
                DP_QI_RIGHT: r_ir <= w_irm1;
                DP_QI_SHIFT: begin
                    r_il <= r_il >> 1;
                    r_ir <= r_ir >> 1;
                end
                DP_PB_RD: r_tmp <= w_rdata;
                DP_P_WR: begin
                    if (!r_outer) r_cj <= r_cj >> 1;
                    r_outer <= 1'b0;
                end
                DP_OUT_UP: begin
                    r_oi    <= r_oi >> 1;
                    r_cj    <= r_ij;
                    r_outer <= 1'b1;
                end
                DP_EMIT: r_out <= r_best;
                default: r_clr <= r_clr;
            endcase
        end
    end

    assign o_stat.wr_ok      = (w_rlo < 32'(ROWS)) && (w_clo < 32'(COLS));
    assign o_stat.q_nonempty = (w_rlo <= w_r1) && (w_clo <= w_c1);
    assign o_stat.clr_last   = &r_clr;
    assign o_stat.l_lt_r     = r_ol < r_or;
    assign o_stat.ol_odd     = r_ol[0];
    assign o_stat.or_odd     = r_or[0];
    assign o_stat.il_lt_ir   = r_il < r_ir;
    assign o_stat.il_odd     = r_il[0];
    assign o_stat.ir_odd     = r_ir[0];
    assign o_stat.cj_gt1     = r_cj > CIW'(1);
    assign o_stat.oi_gt1     = r_oi > OIW'(1);

    assign o_range_min = r_out;
    assign o_done      = r_done;
endmodule

// ===== hdl/range_min_2d_tree.sv =====
// Top level of the rectangle minimum tree.
// Depends on rm2d_pkg, rm2d_ctrl, rm2d_dp (which holds rm2d_ram).
//
//  Channel   Direction  Transfer condition        Contents
//  command   in         start high, busy low      i_opcode, rows, columns, i_cell_value
//  result    out        o_done high (one cycle)   o_range_min, one per query
//
// After reset a clearing pass writes the maximum value into all 4*RP*CP tree
// nodes, one per cycle; busy stays high meanwhile. A write refreshes the
// (log2 RP + 1) * (log2 CP + 1) - 1 nodes above the leaf, each by a step check,
// two child reads and the parent write. A query walks the row levels from the
// leaves up and, for each row node taken, the column levels in check, left,
// right and shift steps, with at most two node reads per column level. The node
// memory has a single read port; a new command is taken only once the last is done.
// Results cannot be held off: each query result is shown for exactly one cycle.
module range_min_2d_tree import rm2d_pkg::*; #(
    parameter int ROWS = 64,
    parameter int COLS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_opcode,
    input  logic [5:0]         i_row_lo,
    input  logic [5:0]         i_col_lo,
    input  logic [5:0]         i_row_hi,
    input  logic [5:0]         i_col_hi,
    input  logic signed [31:0] i_cell_value,
    output logic signed [31:0] o_range_min,
    output logic               o_done
);
    // The controller only looks at start while idle, so a transfer is exactly
    // start with busy low.
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    rm2d_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    // The datapath performs the tree walks that the controller sequences.
    rm2d_dp #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_row_lo     (i_row_lo),
        .i_col_lo     (i_col_lo),
        .i_row_hi     (i_row_hi),
        .i_col_hi     (i_col_hi),
        .i_cell_value (i_cell_value),
        .o_range_min  (o_range_min),
        .o_done       (o_done)
    );
endmodule

// ===== hdl/rm2d_chk.sv =====
// Port-level checker for the rectangle minimum tree, bound to the top level.
// Depends on range_min_2d_tree.
module rm2d_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       i_opcode,
    input logic       o_done
);
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result shown while busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe longer than one cycle");

    a_query_not_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_opcode) |=> !o_done)
        else $error("query result too early");

    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> busy) else $error("not busy during clearing pass");
endmodule

bind range_min_2d_tree rm2d_chk u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_opcode (i_opcode),
    .o_done   (o_done)
);
